>>> design/fir_filter_direct_form_assert.svh
// assertion macros shared by the checker
`ifndef FIR_FILTER_DIRECT_FORM_ASSERT_SVH
`define FIR_FILTER_DIRECT_FORM_ASSERT_SVH

// checked while out of reset
`define FIR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset as well
`define FIR_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> design/fir_pkg.sv
`default_nettype none

package fir_pkg;

   localparam int DEFAULT_TAPS = 64;
   localparam int SAMPLE_W     = 16;
   localparam int TAP_INDEX_W  = 6;
   localparam int PROD_W       = 2 * SAMPLE_W;
   localparam int FRAC_BITS    = 15;
   localparam int ROUND_BIAS   = (1 << FRAC_BITS) - 1;
   localparam int SAMPLE_MAX   = (1 << (SAMPLE_W - 1)) - 1;
   localparam int SAMPLE_MIN   = -(1 << (SAMPLE_W - 1));

   typedef logic [0:0]                  action_type;
   typedef logic [TAP_INDEX_W-1:0]      tap_index_type;
   typedef logic signed [SAMPLE_W-1:0]  sample_type;
   typedef logic signed [PROD_W-1:0]    product_type;

   localparam action_type ACT_FILTER = 1'b0;
   localparam action_type ACT_WRITE  = 1'b1;

   // controls handed to every cell of the ring
   typedef struct packed {
      logic shift;
      logic load;
      logic rotate;
   } cell_ctrl_type;

   // controls for the multiply-accumulate unit
   typedef struct packed {
      logic mul;
      logic clear;
      logic acc;
      logic round;
   } mac_ctrl_type;

endpackage

`default_nettype wire

>>> design/fir_if.sv
`default_nettype none

interface fir_req_if import fir_pkg::*; ();
   logic          valid;
   logic          ready;
   action_type    action;
   tap_index_type tap_index;
   sample_type    tap_value;
   sample_type    sample_in;

   modport source (output valid, output action, output tap_index, output tap_value,
                   output sample_in, input ready);
   modport sink   (input valid, input action, input tap_index, input tap_value,
                   input sample_in, output ready);
endinterface

interface fir_rsp_if import fir_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

>>> design/fir_cell.sv
`default_nettype none

module fir_cell import fir_pkg::*; #(
   parameter int INDEX = 0
) (
   input  wire           clock,
   input  wire           reset,
   input  cell_ctrl_type ctrl,
   input  tap_index_type wr_index,
   input  sample_type    wr_value,
   input  sample_type    shift_in,
   input  sample_type    rot_sample_in,
   input  sample_type    rot_coef_in,
   output sample_type    sample_out,
   output sample_type    coef_out
);

   // cells past the index range can never be written
   localparam bit ADDRESSABLE = INDEX < (1 << TAP_INDEX_W);

   sample_type sample_ff, sample_in;
   sample_type coef_ff, coef_in;
   logic       hit;

   assign hit = ADDRESSABLE && (wr_index == TAP_INDEX_W'(INDEX));

   always_comb begin
      sample_in = sample_ff;
      if (ctrl.shift) begin
         sample_in = shift_in;
      end else if (ctrl.rotate) begin
         sample_in = rot_sample_in;
      end
   end

   always_comb begin
      coef_in = coef_ff;
      if (ctrl.load && hit) begin
         coef_in = wr_value;
      end else if (ctrl.rotate) begin
         coef_in = rot_coef_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         coef_ff   <= '0;
      end else begin
         sample_ff <= sample_in;
         coef_ff   <= coef_in;
      end
   end

   assign sample_out = sample_ff;
   assign coef_out   = coef_ff;

endmodule

`default_nettype wire

>>> design/fir_mac.sv
`default_nettype none

module fir_mac import fir_pkg::*; #(
   parameter int TAPS = DEFAULT_TAPS
) (
   input  wire          clock,
   input  mac_ctrl_type ctrl,
   input  sample_type   sample,
   input  sample_type   coef,
   output sample_type   result
);

   localparam int ACC_W = PROD_W + $clog2(TAPS);

   typedef logic signed [ACC_W-1:0] acc_type;

   product_type prod_ff, prod_in;
   acc_type     acc_ff, acc_in;
   acc_type     bias_ff, bias_in;
   acc_type     quot;

   assign prod_in = PROD_W'(sample) * PROD_W'(coef);

   always_comb begin
      acc_in = acc_ff + ACC_W'(prod_ff);
      if (ctrl.clear) begin
         acc_in = '0;
      end
   end

   // bias negative sums so the shift truncates toward zero
   assign bias_in = acc_ff + (acc_ff[ACC_W-1] ? ACC_W'(ROUND_BIAS) : '0);

   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         prod_ff <= prod_in;
      end
      if (ctrl.clear || ctrl.acc) begin
         acc_ff <= acc_in;
      end
      if (ctrl.round) begin
         bias_ff <= bias_in;
      end
   end

   assign quot = bias_ff >>> FRAC_BITS;

   always_comb begin
      if (quot > ACC_W'(SAMPLE_MAX)) begin
         result = sample_type'(SAMPLE_MAX);
      end else if (quot < ACC_W'(SAMPLE_MIN)) begin
         result = sample_type'(SAMPLE_MIN);
      end else begin
         result = quot[SAMPLE_W-1:0];
      end
   end

endmodule

`default_nettype wire

>>> design/fir_filter_direct_form.sv
// Direct-form FIR filter, signed 16-bit samples, Q1.15 taps.
// req_ch carries one item per valid/ready handshake. With action ACT_WRITE the
// item loads tap_value into tap tap_index (indexes at or beyond TAPS are
// dropped); it gives no result and leaves ready high. With action ACT_FILTER
// the item pushes sample_in into the delay line and gives one sample_out on
// rsp_ch: sum of tap times sample, shifted right by 15 toward zero, saturated.
// Taps and samples sit in a ring of TAPS cells. A sample item shifts the ring
// on acceptance, then the ring rotates once round, cell 0 feeding the single
// multiply-accumulate unit, one tap per cycle. After the sweep the block
// steps through ST_DRAIN, ST_ROUND and ST_DONE; the result is offered on
// rsp_ch in the same cycle as req_ch.ready comes back.
// Ready is high only while no sample item is being filtered.
// The result sits in an output register: the next item is taken while it
// waits. If rsp_ch stalls when a second result is ready, that result holds
// in the unit until the register frees and ready stays low meanwhile.
// Synchronous reset clears every tap and delayed sample to zero and drops
// any pending result.
`default_nettype none

module fir_filter_direct_form import fir_pkg::*; #(
   parameter int TAPS = DEFAULT_TAPS
) (
   input  wire     clock,
   input  wire     reset,
   fir_req_if.sink req_ch,
   fir_rsp_if.source rsp_ch
);

   localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MAC   = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_ROUND = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             prod_vld_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   sample_type       rsp_data_ff;
   logic             req_accept;
   logic             out_free;
   cell_ctrl_type    cell_ctrl;
   mac_ctrl_type     mac_ctrl;
   sample_type       mac_result;

   sample_type cell_sample [TAPS];
   sample_type cell_coef   [TAPS];

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign cell_ctrl.shift  = req_accept && (req_ch.action == ACT_FILTER);
   assign cell_ctrl.load   = req_accept && (req_ch.action == ACT_WRITE);
   assign cell_ctrl.rotate = (state_ff == ST_MAC);

   assign mac_ctrl.mul   = (state_ff == ST_MAC);
   assign mac_ctrl.clear = cell_ctrl.shift;
   assign mac_ctrl.acc   = prod_vld_ff;
   assign mac_ctrl.round = (state_ff == ST_ROUND);

   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      sample_type shift_src;
      if (k == 0) begin : g_head
         assign shift_src = req_ch.sample_in;
      end else begin : g_body
         assign shift_src = cell_sample[k-1];
      end

      fir_cell #(
         .INDEX (k)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (cell_ctrl),
         .wr_index      (req_ch.tap_index),
         .wr_value      (req_ch.tap_value),
         .shift_in      (shift_src),
         .rot_sample_in (cell_sample[(k + 1) % TAPS]),
         .rot_coef_in   (cell_coef[(k + 1) % TAPS]),
         .sample_out    (cell_sample[k]),
         .coef_out      (cell_coef[k])
      );
   end

   fir_mac #(
      .TAPS (TAPS)
   ) u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .sample (cell_sample[0]),
      .coef   (cell_coef[0]),
      .result (mac_result)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (cell_ctrl.shift) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(TAPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         prod_vld_ff  <= (state_ff == ST_MAC);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_data_ff <= mac_result;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample_out = rsp_data_ff;

endmodule

`default_nettype wire

>>> design/fir_checker.sv
`default_nettype none

`include "fir_filter_direct_form_assert.svh"

module fir_checker import fir_pkg::*; (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input action_type req_action,
   input wire        rsp_valid,
   input wire        rsp_ready
);

   // a stalled result stays offered
   `FIR_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   // nothing is offered straight after reset
   `FIR_ASSERT_RST(a_rsp_reset, reset |=> !rsp_valid, "result offered after reset")

   // a sample item keeps the block busy on the following cycle
   `FIR_ASSERT(a_busy_after_sample, req_valid && req_ready && req_action == ACT_FILTER |=> !req_ready, "sample item did not start the tap sweep")

   // a new result appears only as the block goes idle again
   `FIR_ASSERT(a_rsp_on_idle, $rose(rsp_valid) |-> req_ready, "result offered while busy")

endmodule

bind fir_filter_direct_form fir_checker u_fir_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_action (req_ch.action),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready)
);

`default_nettype wire
